// ===== rtl/core/usan_pkg.sv =====
// Shared types, constants and helper functions of the UTF-8 sanitizer.
package usan_pkg;

   localparam int LENGTH_BITS_DEF = 16;
   localparam int CFG_W = 16;
   localparam logic [CFG_W-1:0] MAX_LENGTH_RESET = 16'hFFFF;

   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 8;
   localparam int MAX_BURST = 4;
   localparam int BURST_W = $clog2(MAX_BURST + 1);

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_TAG    = 8'h80;
   localparam logic [7:0] LEAD2_LO    = 8'hC2;
   localparam logic [7:0] LEAD2_HI    = 8'hDF;
   localparam logic [7:0] LEAD3_LO    = 8'hE0;
   localparam logic [7:0] LEAD3_HI    = 8'hEF;
   localparam logic [7:0] LEAD4_LO    = 8'hF0;
   localparam logic [7:0] LEAD4_HI    = 8'hF4;
   localparam logic [7:0] LEAD_E0     = 8'hE0;
   localparam logic [7:0] LEAD_ED     = 8'hED;
   localparam logic [7:0] LEAD_F0     = 8'hF0;
   localparam logic [7:0] LEAD_F4     = 8'hF4;
   localparam logic [7:0] E0_MIN      = 8'hA0;
   localparam logic [7:0] ED_MAX      = 8'h9F;
   localparam logic [7:0] F0_MIN      = 8'h90;
   localparam logic [7:0] F4_MAX      = 8'h8F;
   localparam logic [7:0] REPL_BYTE   = 8'h3F;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } usan_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
   } usan_rsp_type;

   // Entry of the queue between the front and the decoder.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       feed;
   } usan_mid_type;

   // Burst of results from the decoder into the result queue.
   typedef struct packed {
      logic [BURST_W-1:0]                  count;
      usan_rsp_type [MAX_BURST-1:0]        item;
      logic                                mark_prev;
      logic                                commit;
   } usan_push_type;

   // Number of continuation bytes a lead byte asks for; zero for a non-lead.
   function automatic logic [1:0] lead_need(input logic [7:0] c);
      logic [1:0] n;
      n = 2'd0;
      if (c >= LEAD2_LO && c <= LEAD2_HI) n = 2'd1;
      else if (c >= LEAD3_LO && c <= LEAD3_HI) n = 2'd2;
      else if (c >= LEAD4_LO && c <= LEAD4_HI) n = 2'd3;
      return n;
   endfunction

endpackage

// ===== rtl/core/usan_front.sv =====
// Input stage: configuration register, length limit and forwarding to the decoder.
module usan_front #(
   parameter int LENGTH_BITS = usan_pkg::LENGTH_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  usan_pkg::usan_req_type        req_data,
   output logic                          full,
   input  logic                          csr_wr_en,
   input  logic [usan_pkg::CFG_W-1:0]    csr_wr_data,
   input  logic                          mid_full,
   output logic                          mid_push,
   output usan_pkg::usan_mid_type        mid_item
);

   localparam int CMP_W = (LENGTH_BITS > usan_pkg::CFG_W) ? LENGTH_BITS : usan_pkg::CFG_W;
   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

   logic [usan_pkg::CFG_W-1:0] max_len_ff;
   logic [LENGTH_BITS-1:0]     seen_ff, seen_in, seen_inc;
   logic                       trunc_ff, trunc_in;
   logic                       accept, fed, trunc_after;
   logic [CMP_W-1:0]           seen_x, lim_x, inc_x;

   always_comb begin
      accept      = push && !mid_full;
      seen_x      = CMP_W'(seen_ff);
      lim_x       = CMP_W'(max_len_ff);
      seen_inc    = seen_ff + 1'b1;
      inc_x       = CMP_W'(seen_inc);
      fed         = !trunc_ff && (seen_x < lim_x) && (seen_ff != COUNT_MAX);
      trunc_after = (inc_x >= lim_x) || (seen_inc == COUNT_MAX);
      seen_in     = seen_ff;
      trunc_in    = trunc_ff;
      if (accept) begin
         if (req_data.in_last) begin
            seen_in  = '0;
            trunc_in = 1'b0;
         end else if (fed) begin
            seen_in  = seen_inc;
            trunc_in = trunc_after;
         end else begin
            trunc_in = 1'b1;
         end
      end
      mid_push      = accept && (fed || req_data.in_last);
      mid_item.data = req_data.in_byte;
      mid_item.last = req_data.in_last;
      mid_item.feed = fed;
      full          = mid_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= usan_pkg::MAX_LENGTH_RESET;
         seen_ff    <= '0;
         trunc_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) max_len_ff <= csr_wr_data;
         seen_ff  <= seen_in;
         trunc_ff <= trunc_in;
      end
   end

endmodule

// ===== rtl/core/usan_fifo.sv =====
// Short queue between the front and the decoder.
module usan_fifo #(
   parameter int DEPTH = usan_pkg::MID_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  usan_pkg::usan_mid_type wr_item,
   output logic                   full,
   input  logic                   rd_en,
   output usan_pkg::usan_mid_type rd_item,
   output logic                   empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = AW + 1;

   usan_pkg::usan_mid_type mem_ff [DEPTH];
   logic [PW-1:0]          wr_ff, wr_in, rd_ff, rd_in, fill;

   always_comb begin
      fill    = wr_ff - rd_ff;
      full    = (fill == PW'(DEPTH));
      empty   = (fill == '0);
      rd_item = mem_ff[rd_ff[AW-1:0]];
      wr_in   = wr_ff + PW'(wr_en && !full);
      rd_in   = rd_ff + PW'(rd_en && !empty);
   end

   always_ff @(posedge clock) begin
      if (wr_en && !full) mem_ff[wr_ff[AW-1:0]] <= wr_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

endmodule

// ===== rtl/core/usan_back.sv =====
// Decoder: collects sequences, checks them and replays the bytes of a failed one.
module usan_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mid_empty,
   input  usan_pkg::usan_mid_type  mid_item,
   output logic                    mid_pop,
   input  logic                    space_ok,
   output usan_pkg::usan_push_type push_out
);

   localparam int BW = usan_pkg::BURST_W;

   logic [7:0] held_ff [4];
   logic [7:0] held_in [4];
   logic [2:0] hc_ff, hc_in;
   logic [1:0] need_ff, need_in;
   logic [7:0] rpl_ff [3];
   logic [7:0] rpl_in [3];
   logic [1:0] rpl_n_ff, rpl_n_in;
   logic       step_last_ff, step_last_in;
   logic       step_emit_ff, step_emit_in;

   logic [7:0] h [4];
   logic [7:0] rem [3];
   logic [1:0] rem_n;
   logic [7:0] c;
   logic [1:0] lead;
   logic       src_rpl, take_mid, go, cur_feed, cur_last, ok, step_end;

   always_comb begin
      src_rpl  = (rpl_n_ff != 2'd0);
      take_mid = !src_rpl && !mid_empty && space_ok;
      go       = src_rpl ? space_ok : take_mid;
      c        = src_rpl ? rpl_ff[0] : mid_item.data;
      cur_feed = src_rpl || mid_item.feed;
      cur_last = src_rpl ? step_last_ff : mid_item.last;
      lead     = usan_pkg::lead_need(c);

      // Replay bytes still waiting behind the one taken now.
      rem[0] = rpl_ff[1];
      rem[1] = rpl_ff[2];
      rem[2] = rpl_ff[2];
      rem_n  = src_rpl ? rpl_n_ff - 2'd1 : 2'd0;

      for (int k = 0; k < 4; k++) h[k] = (hc_ff == 3'(k)) ? c : held_ff[k];

      ok = 1'b1;
      for (int k = 1; k < 4; k++) begin
         if ((2'(k) <= need_ff) && ((h[k] & usan_pkg::CONT_MASK) != usan_pkg::CONT_TAG))
            ok = 1'b0;
      end
      if (need_ff == 2'd2 && ((h[0] == usan_pkg::LEAD_E0 && h[1] < usan_pkg::E0_MIN) ||
                              (h[0] == usan_pkg::LEAD_ED && h[1] > usan_pkg::ED_MAX)))
         ok = 1'b0;
      if (need_ff == 2'd3 && ((h[0] == usan_pkg::LEAD_F0 && h[1] < usan_pkg::F0_MIN) ||
                              (h[0] == usan_pkg::LEAD_F4 && h[1] > usan_pkg::F4_MAX)))
         ok = 1'b0;

      held_in      = held_ff;
      hc_in        = hc_ff;
      need_in      = need_ff;
      rpl_in       = rpl_ff;
      rpl_n_in     = rpl_n_ff;
      step_last_in = step_last_ff;
      step_emit_in = step_emit_ff;
      push_out     = '0;

      if (go) begin
         rpl_in[0] = rem[0];
         rpl_in[1] = rem[1];
         rpl_in[2] = rem[2];
         rpl_n_in  = rem_n;
         if (take_mid) step_last_in = mid_item.last;

         if (cur_feed) begin
            if (hc_ff == 3'd0) begin
               if (c < usan_pkg::ASCII_LIMIT) begin
                  push_out.count        = BW'(1);
                  push_out.item[0]      = '{out_byte: c, out_valid: 1'b1, out_last: 1'b0};
               end else if (lead == 2'd0) begin
                  push_out.count        = BW'(1);
                  push_out.item[0]      = '{out_byte: usan_pkg::REPL_BYTE, out_valid: 1'b1,
                                            out_last: 1'b0};
               end else begin
                  held_in[0] = c;
                  hc_in      = 3'd1;
                  need_in    = lead;
               end
            end else begin
               held_in = h;
               hc_in   = hc_ff + 3'd1;
               if (hc_ff == 3'(need_ff)) begin
                  // Sequence complete: copy it whole or replace its lead.
                  hc_in   = 3'd0;
                  need_in = 2'd0;
                  if (ok) begin
                     push_out.count = BW'(hc_ff + 3'd1);
                     for (int k = 0; k < 4; k++)
                        push_out.item[k] = '{out_byte: h[k], out_valid: 1'b1, out_last: 1'b0};
                  end else begin
                     push_out.count   = BW'(1);
                     push_out.item[0] = '{out_byte: usan_pkg::REPL_BYTE, out_valid: 1'b1,
                                          out_last: 1'b0};
                     rpl_n_in = need_ff + rem_n;
                     unique case (need_ff)
                        2'd1: begin
                           rpl_in[0] = h[1]; rpl_in[1] = rem[0]; rpl_in[2] = rem[1];
                        end
                        2'd2: begin
                           rpl_in[0] = h[1]; rpl_in[1] = h[2]; rpl_in[2] = rem[0];
                        end
                        2'd3: begin
                           rpl_in[0] = h[1]; rpl_in[1] = h[2]; rpl_in[2] = h[3];
                        end
                        default: begin
                           rpl_in[0] = h[1]; rpl_in[1] = rem[0]; rpl_in[2] = rem[1];
                        end
                     endcase
                  end
               end
            end
         end
      end

      step_end        = go && (rpl_n_in == 2'd0);
      push_out.commit = step_end;
      if (go) step_emit_in = step_end ? 1'b0 : (step_emit_ff || (push_out.count != '0));

      if (step_end && cur_last) begin
         // String end drops any unfinished sequence and tags the final result.
         hc_in   = 3'd0;
         need_in = 2'd0;
         if (push_out.count != '0) begin
            for (int k = 0; k < 4; k++)
               if (BW'(k) == push_out.count - BW'(1)) push_out.item[k].out_last = 1'b1;
         end else if (step_emit_ff) begin
            push_out.mark_prev = 1'b1;
         end else begin
            push_out.count   = BW'(1);
            push_out.item[0] = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
         end
      end

      mid_pop = take_mid;
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      rpl_ff  <= rpl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff        <= 3'd0;
         need_ff      <= 2'd0;
         rpl_n_ff     <= 2'd0;
         step_last_ff <= 1'b0;
         step_emit_ff <= 1'b0;
      end else begin
         hc_ff        <= hc_in;
         need_ff      <= need_in;
         rpl_n_ff     <= rpl_n_in;
         step_last_ff <= step_last_in;
         step_emit_ff <= step_emit_in;
      end
   end

endmodule

// ===== rtl/core/usan_rsp_queue.sv =====
// Result queue: burst writes, commit at the end of each input transaction, single read.
module usan_rsp_queue #(
   parameter int DEPTH = usan_pkg::RSP_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  usan_pkg::usan_push_type push_in,
   output logic                    space_ok,
   input  logic                    pop,
   output logic                    empty,
   output usan_pkg::usan_rsp_type  rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = AW + 1;

   usan_pkg::usan_rsp_type mem_ff [DEPTH];
   logic [PW-1:0]          wr_ff, wr_in, cm_ff, cm_in, rd_ff, rd_in, prev;

   always_comb begin
      empty    = (rd_ff == cm_ff);
      rsp_data = mem_ff[rd_ff[AW-1:0]];
      space_ok = ((wr_ff - rd_ff) <= PW'(DEPTH - usan_pkg::MAX_BURST));
      wr_in    = wr_ff + PW'(push_in.count);
      cm_in    = push_in.commit ? wr_in : cm_ff;
      rd_in    = rd_ff + PW'(pop && !empty);
      prev     = wr_ff - PW'(1);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < usan_pkg::MAX_BURST; i++) begin
         if (usan_pkg::BURST_W'(i) < push_in.count)
            mem_ff[AW'(wr_ff[AW-1:0] + AW'(i))] <= push_in.item[i];
      end
      if (push_in.mark_prev) mem_ff[prev[AW-1:0]].out_last <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         cm_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         cm_ff <= cm_in;
         rd_ff <= rd_in;
      end
   end

endmodule

// ===== rtl/core/utf8_sanitizer.sv =====
// Top level of the streaming UTF-8 sanitizer.
//
// The sanitizer takes a string one byte per transaction and passes well-formed
// UTF-8 through unchanged, replacing a stray or failed lead byte with '?' and
// re-examining the bytes that were collected after it. The input side accepts
// one byte per cycle whenever the four-entry queue in front of the decoder has
// room. While the result queue has room, the decoder performs one decode step
// per cycle: a well-formed byte takes one step, and a sequence that fails its
// checks takes one extra step for each of the one to three bytes it replays.
// Results of an input transaction become visible together once its last
// decode step is done, so a byte is first written into the decoder queue and
// then committed into the result queue before it can be popped.
// The eight-entry result queue absorbs the burst of up to four bytes
// that a completed sequence releases, and the decoder pauses only when fewer
// than four result slots are free. A string that ends, or runs into the length
// limit, in the middle of a sequence loses that sequence. When the final
// transaction of a string yields nothing, one empty end marker with out_valid
// low and out_last high is returned instead. The max_length register is
// written through csr_wr_en and csr_wr_data, takes effect at once and should
// only be changed while no transaction is in flight.
module utf8_sanitizer #(
   parameter int LENGTH_BITS = usan_pkg::LENGTH_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  usan_pkg::usan_req_type      req_data,
   output logic                        empty,
   input  logic                        pop,
   output usan_pkg::usan_rsp_type      rsp_data,
   input  logic                        csr_wr_en,
   input  logic [usan_pkg::CFG_W-1:0]  csr_wr_data
);

   // Forwarded bytes travel from the front to the decoder through this queue.
   logic                    mid_push, mid_full, mid_pop, mid_empty;
   usan_pkg::usan_mid_type  mid_wr, mid_rd;

   // The decoder hands finished results to the result queue in bursts.
   usan_pkg::usan_push_type burst;
   logic                    space_ok;

   usan_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_data    (req_data),
      .full        (full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mid_full    (mid_full),
      .mid_push    (mid_push),
      .mid_item    (mid_wr)
   );

   usan_fifo #(
      .DEPTH (usan_pkg::MID_DEPTH)
   ) u_mid (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_push),
      .wr_item (mid_wr),
      .full    (mid_full),
      .rd_en   (mid_pop),
      .rd_item (mid_rd),
      .empty   (mid_empty)
   );

   usan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_rd),
      .mid_pop   (mid_pop),
      .space_ok  (space_ok),
      .push_out  (burst)
   );

   usan_rsp_queue #(
      .DEPTH (usan_pkg::RSP_DEPTH)
   ) u_rsp (
      .clock    (clock),
      .reset    (reset),
      .push_in  (burst),
      .space_ok (space_ok),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/core/usan_checker.sv =====
// Port-level assertions for the sanitizer and the bind that attaches them.
module usan_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   full,
   input logic                   empty,
   input logic                   pop,
   input usan_pkg::usan_rsp_type rsp_data
);

   // Reset leaves both queues empty.
   a_reset_idle: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   // An empty end marker always closes its string.
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_data.out_valid |-> rsp_data.out_last)
      else $error("end marker without out_last");

   // An empty end marker carries a zero byte.
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_data.out_valid |-> rsp_data.out_byte == 8'h00)
      else $error("end marker with nonzero byte");

   // A visible result is never withdrawn or changed before it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("result changed while waiting");

endmodule

bind utf8_sanitizer usan_checker u_usan_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

// ===== test/usan_output_check.sv =====
// Result predictor and comparator for the UTF-8 sanitizer testbench.
`timescale 1ns / 100ps

module usan_output_check (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic                        full,
   input  usan_pkg::usan_req_type      req_data,
   input  logic                        empty,
   input  logic                        pop,
   input  usan_pkg::usan_rsp_type      rsp_data,
   input  logic                        csr_wr_en,
   input  logic [usan_pkg::CFG_W-1:0]  csr_wr_data,
   output int                          fail_count,
   output int                          pending
);

   localparam logic [7:0]  QMARK        = 8'h3F;
   localparam logic [15:0] SEEN_CEILING = 16'hFFFF;

   // Predicted state of the decoder.
   logic [15:0]  max_len;
   logic [7:0]   held [4];
   logic [2:0]   held_cnt;
   logic [1:0]   need_cnt;
   logic [15:0]  seen;
   logic         trunc;

   usan_pkg::usan_rsp_type clean_q [$];
   usan_pkg::usan_rsp_type step_res [4];
   usan_pkg::usan_rsp_type want;
   int           step_n;
   int           errors = 0;
   int           waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   // Continuation bytes announced by a lead byte; zero when it is no lead.
   function automatic logic [1:0] seq_tail(input logic [7:0] c);
      if (c >= 8'hF0 && c <= 8'hF4) return 2'd3;
      if (c >= 8'hE0 && c <= 8'hEF) return 2'd2;
      if (c >= 8'hC2 && c <= 8'hDF) return 2'd1;
      return 2'd0;
   endfunction

   // A complete sequence passes if all its tail bytes are continuations and it
   // is neither overlong, a surrogate nor beyond the last code point.
   function automatic bit seq_valid();
      for (int k = 1; k <= need_cnt; k++) begin
         if (held[k][7:6] != 2'b10) return 1'b0;
      end
      case (need_cnt)
         2'd2: begin
            if ((held[0] == 8'hE0 && held[1] < 8'hA0) || (held[0] == 8'hED && held[1] > 8'h9F))
               return 1'b0;
         end
         2'd3: begin
            if ((held[0] == 8'hF0 && held[1] < 8'h90) || (held[0] == 8'hF4 && held[1] > 8'h8F))
               return 1'b0;
         end
         default: ;
      endcase
      return 1'b1;
   endfunction

   function automatic void put(input logic [7:0] b, input logic v);
      if (step_n < 4) begin
         step_res[step_n] = {b, v, 1'b0};
         step_n++;
      end
   endfunction

   // Runs one byte through the decoder; a failed sequence replays its tail.
   function automatic void sanitize_byte(input logic [7:0] b);
      logic [7:0] q [8];
      logic [7:0] t [8];
      logic [7:0] c;
      int qh, qn, tn;
      q[0] = b;
      qh = 0;
      qn = 1;
      while (qh < qn) begin
         c = q[qh];
         qh++;
         if (held_cnt == 3'd0) begin
            if (c < 8'h80) begin
               put(c, 1'b1);
            end else if (seq_tail(c) == 2'd0) begin
               put(QMARK, 1'b1);
            end else begin
               held[0] = c;
               held_cnt = 3'd1;
               need_cnt = seq_tail(c);
            end
         end else begin
            held[held_cnt[1:0]] = c;
            held_cnt++;
            if (held_cnt == need_cnt + 3'd1) begin
               if (seq_valid()) begin
                  for (int k = 0; k < held_cnt; k++) put(held[k], 1'b1);
               end else begin
                  put(QMARK, 1'b1);
                  tn = 0;
                  for (int k = 1; k < held_cnt; k++) begin
                     t[tn] = held[k];
                     tn++;
                  end
                  while (qh < qn) begin
                     t[tn] = q[qh];
                     tn++;
                     qh++;
                  end
                  for (int k = 0; k < tn; k++) q[k] = t[k];
                  qh = 0;
                  qn = tn;
               end
               held_cnt = 3'd0;
               need_cnt = 2'd0;
            end
         end
      end
   endfunction

   function automatic void sanitize_step(input usan_pkg::usan_req_type r);
      step_n = 0;
      if (!trunc && seen < max_len && seen != SEEN_CEILING) begin
         sanitize_byte(r.in_byte);
         seen++;
         if (seen >= max_len || seen == SEEN_CEILING) trunc = 1'b1;
      end else begin
         trunc = 1'b1;
      end
      if (r.in_last) begin
         held_cnt = 3'd0;
         need_cnt = 2'd0;
         seen = '0;
         trunc = 1'b0;
         if (step_n == 0) put(8'h00, 1'b0);
         step_res[step_n-1].out_last = 1'b1;
      end
      for (int k = 0; k < step_n; k++) clean_q.push_back(step_res[k]);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] got_v);
      if (exp_v !== got_v) begin
         errors++;
         $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         max_len = usan_pkg::MAX_LENGTH_RESET;
         held_cnt = 3'd0;
         need_cnt = 2'd0;
         seen = '0;
         trunc = 1'b0;
         clean_q.delete();
      end else begin
         if (push && !full) sanitize_step(req_data);
         if (csr_wr_en) max_len = csr_wr_data;
         if (pop && !empty) begin
            if (clean_q.size() == 0) begin
               errors++;
               $error("result transaction with none expected: out_byte 'h%0h",
                      rsp_data.out_byte);
            end else begin
               want = clean_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("out_valid", want.out_valid, rsp_data.out_valid);
               check_field("out_last", want.out_last, rsp_data.out_last);
            end
         end
      end
      waiting <= clean_q.size();
   end

endmodule

// ===== test/utf8_sanitizer_tb.sv =====
// Stimulus, idling and verdict of the UTF-8 sanitizer testbench.
`timescale 1ns / 100ps

module utf8_sanitizer_tb;

   localparam int HALF_PERIOD = 4;
   localparam int LONG_STALL  = 80;
   localparam int DRAIN_GAP   = 16;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       push = 1'b0;
   logic                       full;
   usan_pkg::usan_req_type     req_data = '0;
   logic                       empty;
   logic                       pop = 1'b0;
   usan_pkg::usan_rsp_type     rsp_data;
   logic                       csr_wr_en = 1'b0;
   logic [usan_pkg::CFG_W-1:0] csr_wr_data = '0;

   int fail_count;
   int pending;

   // Percentages of cycles in which each side idles.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // The stimulus asks for a long receiver stall by bumping stall_asked; the
   // receiver process counts the stall out on its own.
   int stall_asked = 0;
   int stall_served = 0;
   int stall_left = 0;

   int         sent = 0;
   logic [7:0] text [$];

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   utf8_sanitizer u_top (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   usan_output_check u_check (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Receiver: pops at random, or holds off completely for a long stall so
   // that both internal queues fill up and the block raises full.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_asked != stall_served) begin
         pop <= 1'b0;
         stall_left <= LONG_STALL;
         stall_served <= stall_served + 1;
      end else begin
         pop <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offers one byte, after a random gap, and returns at the edge at which the
   // transaction is accepted. Push stays high so that back-to-back bytes flow.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < req_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= {b, fin};
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
   endtask

   // Sends the collected string with in_last on its final byte.
   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
      text.delete();
   endtask

   // Appends one character to the string. Most are well formed with random
   // content; the rest are noise, sequences that break the overlong, surrogate
   // and code point bounds, and leads followed by junk or cut short.
   function automatic void add_char();
      int         kind;
      logic [7:0] lead;
      kind = $urandom_range(99);
      if (kind < 28) begin
         text.push_back(8'($urandom_range(8'h7F, 8'h00)));
      end else if (kind < 42) begin
         text.push_back(8'($urandom_range(8'hDF, 8'hC2)));
         text.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end else if (kind < 58) begin
         lead = 8'($urandom_range(8'hEF, 8'hE0));
         text.push_back(lead);
         if (lead == 8'hE0) text.push_back(8'($urandom_range(8'hBF, 8'hA0)));
         else if (lead == 8'hED) text.push_back(8'($urandom_range(8'h9F, 8'h80)));
         else text.push_back(8'($urandom_range(8'hBF, 8'h80)));
         text.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end else if (kind < 70) begin
         lead = 8'($urandom_range(8'hF4, 8'hF0));
         text.push_back(lead);
         if (lead == 8'hF0) text.push_back(8'($urandom_range(8'hBF, 8'h90)));
         else if (lead == 8'hF4) text.push_back(8'($urandom_range(8'h8F, 8'h80)));
         else text.push_back(8'($urandom_range(8'hBF, 8'h80)));
         repeat (2) text.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end else if (kind < 80) begin
         text.push_back(8'($urandom_range(8'hFF, 8'h00)));
      end else if (kind < 90) begin
         // Second byte just outside the allowed range of E0, ED, F0 or F4.
         case ($urandom_range(3))
            0: begin
               text.push_back(8'hE0);
               text.push_back(8'($urandom_range(8'h9F, 8'h80)));
            end
            1: begin
               text.push_back(8'hED);
               text.push_back(8'($urandom_range(8'hBF, 8'hA0)));
            end
            2: begin
               text.push_back(8'hF0);
               text.push_back(8'($urandom_range(8'h8F, 8'h80)));
               text.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            default: begin
               text.push_back(8'hF4);
               text.push_back(8'($urandom_range(8'hBF, 8'h90)));
               text.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
         endcase
         text.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end else begin
         text.push_back(8'($urandom_range(8'hF4, 8'hC2)));
         repeat ($urandom_range(2)) text.push_back(8'($urandom_range(8'hFF, 8'h00)));
      end
   endfunction

   // Random strings of one to six characters until count more bytes are sent.
   task automatic random_strings(input int count);
      int goal;
      goal = sent + count;
      while (sent < goal) begin
         repeat ($urandom_range(6, 1)) add_char();
         send_text();
      end
   endtask

   // Waits until every expected result has come back, plus some cycles for
   // ignored bytes still inside the block, then writes max_length.
   task automatic set_max_length(input logic [usan_pkg::CFG_W-1:0] value);
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Phase one: the sender idles rarely, the receiver often. max_length
      // keeps its reset value.
      req_idle_pct = 11;
      rsp_idle_pct = 54;

      // ASCII extremes, then the smallest two-byte form, the lowest three-byte
      // form after E0 and the highest code point under F4.
      text = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text();
      // Stray bytes: a bare continuation, an overlong lead and leads above F4.
      text = '{8'h80, 8'hC1, 8'hF5, 8'hFF};
      send_text();
      // A surrogate, then a four-byte lead followed by ASCII, which gets
      // replayed after the lead is replaced.
      text = '{8'hED, 8'hA0, 8'h80, 8'hF0, 8'h41, 8'h42, 8'h43};
      send_text();
      // A sequence left unfinished at the string end: only the end marker.
      text = '{8'hE2, 8'h82};
      send_text();

      random_strings(30);

      // A zero limit ignores every byte, so each string yields an end marker.
      set_max_length('0);
      text = '{8'h41, 8'h42};
      send_text();
      text = '{8'hC3};
      send_text();

      // Phase two: the sender idles often, the receiver rarely. Short limits
      // cut most strings, many of them in the middle of a sequence.
      req_idle_pct = 54;
      rsp_idle_pct = 11;
      set_max_length(16'd5);
      random_strings(20);
      set_max_length(16'd1);
      random_strings(8);

      // Phase three: nobody idles, except for one long receiver stall while
      // the sender keeps offering bytes.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_max_length(16'hFFFF);
      stall_asked++;
      random_strings(20);

      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("utf8_sanitizer test passed");
      end else begin
         $display("utf8_sanitizer test failed");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin
      #5_000_000;
      $display("utf8_sanitizer test failed");
      $finish;
   end

endmodule
